// ===== rtl/esra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esra_pkg: shared types and constants of the sized endian RAM
// Address geometry of the word store and the control word that travels
// with an access from the memory read to the output register.
// ----------------------------------------------------------------------------
package esra_pkg;

	// byte address width and the word store it implies
	localparam int AddrBits  = 16;
	localparam int WordBits  = AddrBits - 3;
	localparam int WordCount = 1 << WordBits;

	// access kinds
	localparam logic CmdRead  = 1'b0;
	localparam logic CmdWrite = 1'b1;

	// control of an access in flight
	typedef struct packed {
		logic       is_read;
		logic       ok;
		logic [2:0] off;
		logic [3:0] nbytes;
		logic       big;
	} acc_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/esra_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esra_ifs: channel interfaces of the sized endian RAM
// Request, response and configuration channels, each valid/ready.
// ----------------------------------------------------------------------------
interface esra_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [1:0]  access_size;
	logic        big_endian;
	logic [15:0] byte_address;
	logic [63:0] write_data;

	modport source (output valid, cmd, access_size, big_endian, byte_address, write_data,
		input ready);
	modport sink (input valid, cmd, access_size, big_endian, byte_address, write_data,
		output ready);
endinterface

interface esra_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] read_data;
	logic        accepted;

	modport source (output valid, read_data, accepted, input ready);
	modport sink (input valid, read_data, accepted, output ready);
endinterface

interface esra_cfg_if;
	logic valid;
	logic ready;
	logic write_protect;

	modport source (output valid, write_protect, input ready);
	modport sink (input valid, write_protect, output ready);
endinterface
`default_nettype wire

// ===== rtl/endian_sized_ram_access.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// endian_sized_ram_access: byte-addressed RAM with sized endian access
// A 64-bit word store served one 1/2/4/8-byte access per request word.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one access per word (read or write, size, byte order, address,
//          data). The address is aligned down to the access size.
//   rsp  : one word per request: read data zero-extended (zero for writes)
//          and an accepted flag that is low for a write refused by protection.
//   cfg  : write of the write_protect bit; always ready. Change it only while
//          no request is outstanding.
// Path: an accepted request is read from memory into the read stage, then
//   moves to the output register, where its response becomes valid.
// Throughput: one access per cycle unless rsp stalls; the single memory port
//   is used once per access, writes and registered reads in the accept cycle.
// Reset: the store is cleared one word per cycle after arst_n is released;
//   req.ready stays low during that pass.
// Stall: while rsp.ready is low the response is held; one more access can be
//   taken into the read stage, then req.ready drops until rsp drains.
// ----------------------------------------------------------------------------
module endian_sized_ram_access (
	input  wire logic clk,
	input  wire logic arst_n,
	esra_req_if.sink   req,
	esra_rsp_if.source rsp,
	esra_cfg_if.sink   cfg
);

	localparam int WB = esra_pkg::WordBits;

	logic [63:0]   mem [esra_pkg::WordCount];

	logic          clearing_q;
	logic [WB-1:0] clr_idx_q;
	logic          wprot_q;

	logic                s1_valid_q;
	esra_pkg::acc_ctl_t  ctl_s1;
	logic [63:0]         word_s1;

	logic          rsp_valid_q;
	logic [63:0]   rsp_data_q;
	logic          rsp_acc_q;

	logic          out_free;
	logic          acc;
	logic          is_wr;
	logic [2:0]    req_off;
	logic [2:0]    off_mask;
	logic [3:0]    req_n;
	logic [WB-1:0] req_widx;
	logic [7:0]    wr_be;
	logic [63:0]   wr_word;
	logic          mem_we;
	logic [WB-1:0] mem_widx;
	logic [7:0]    mem_be;
	logic [63:0]   mem_wdata;
	logic [63:0]   rd_fmt;

	// handshakes
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = !clearing_q && (!s1_valid_q || out_free);
	assign acc       = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// decode size and alignment
	always_comb begin
		case (req.access_size)
			2'd0:    off_mask = 3'b111;
			2'd1:    off_mask = 3'b110;
			2'd2:    off_mask = 3'b100;
			default: off_mask = 3'b000;
		endcase
	end
	assign req_n    = 4'd1 << req.access_size;
	assign req_off  = req.byte_address[2:0] & off_mask;
	assign req_widx = req.byte_address[15:3];
	assign is_wr    = (req.cmd == esra_pkg::CmdWrite);

	// place write bytes on their lanes
	always_comb begin : wr_lanes
		logic [3:0] pos;
		logic [3:0] rel;
		logic [3:0] src;
		wr_be   = '0;
		wr_word = '0;
		for (int b = 0; b < 8; b++) begin
			pos = 4'(b);
			rel = pos - {1'b0, req_off};
			src = req.big_endian ? (req_n - 4'd1 - rel) : rel;
			if (pos >= {1'b0, req_off} && rel < req_n) begin
				wr_be[b]          = 1'b1;
				wr_word[8*b +: 8] = req.write_data[8*src[2:0] +: 8];
			end
		end
	end

	// memory port: clearing pass or access write
	always_comb begin
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_widx  = clr_idx_q;
			mem_be    = '1;
			mem_wdata = '0;
		end else begin
			mem_we    = acc && is_wr && !wprot_q;
			mem_widx  = req_widx;
			mem_be    = wr_be;
			mem_wdata = wr_word;
		end
	end

	// store and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			for (int b = 0; b < 8; b++) begin
				if (mem_be[b]) begin
					mem[mem_widx][8*b +: 8] <= mem_wdata[8*b +: 8];
				end
			end
		end
		if (acc && !is_wr) begin
			word_s1 <= mem[req_widx];
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + WB'(1);
			if (clr_idx_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// write protect register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wprot_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			wprot_q <= cfg.write_protect;
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (out_free) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1.is_read <= !is_wr;
			ctl_s1.ok      <= !(is_wr && wprot_q);
			ctl_s1.off     <= req_off;
			ctl_s1.nbytes  <= req_n;
			ctl_s1.big     <= req.big_endian;
		end
	end

	// gather read bytes into value order
	always_comb begin : rd_lanes
		logic [3:0] pos;
		logic [3:0] rel;
		logic [2:0] src;
		rd_fmt = '0;
		for (int l = 0; l < 8; l++) begin
			pos = 4'(l);
			rel = ctl_s1.big ? (ctl_s1.nbytes - 4'd1 - pos) : pos;
			src = ctl_s1.off + rel[2:0];
			if (pos < ctl_s1.nbytes) begin
				rd_fmt[8*l +: 8] = word_s1[8*src +: 8];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_q) begin
			rsp_data_q <= ctl_s1.is_read ? rd_fmt : 64'd0;
			rsp_acc_q  <= ctl_s1.ok;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_data_q;
	assign rsp.accepted  = rsp_acc_q;

endmodule
`default_nettype wire

// ===== verif/tb_endian_sized_ram_access.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_endian_sized_ram_access: self-checking bench for the sized endian RAM
// A queue-fed driver sends access words and a clocked monitor compares each
// response word with a shadow RAM that replays every accepted access.
// Directed accesses cover sizes, byte orders, unaligned and edge addresses and
// write protection. Random phases then toggle protection and idle both sides.
// ----------------------------------------------------------------------------
module tb_endian_sized_ram_access;

	localparam logic [1:0] Size1 = 2'd0;
	localparam logic [1:0] Size2 = 2'd1;
	localparam logic [1:0] Size4 = 2'd2;
	localparam logic [1:0] Size8 = 2'd3;

	localparam logic CmdRd = esra_pkg::CmdRead;
	localparam logic CmdWr = esra_pkg::CmdWrite;

	localparam int CycleLimit   = 400000;
	localparam int SettleCycles = 4;
	localparam int PhaseCount   = 7;
	localparam int PhaseWords   = 250;

	typedef struct packed {
		logic        cmd;
		logic [1:0]  access_size;
		logic        big_endian;
		logic [15:0] byte_address;
		logic [63:0] write_data;
	} ram_access_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        accepted;
	} ram_reply_t;

	logic clk = 1'b0;
	logic arst_n;

	esra_req_if req_ch ();
	esra_rsp_if rsp_ch ();
	esra_cfg_if cfg_ch ();

	endian_sized_ram_access dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// shadow state of the RAM
	logic [63:0] shadow_ram [esra_pkg::WordCount];
	logic        protect_shadow;

	ram_access_t access_queue [$];
	ram_reply_t  expected_replies [$];
	ram_reply_t  want;

	int  error_count = 0;
	int  cycle_count = 0;
	int  send_gap    = 0;
	int  rsp_stall   = 0;
	int  idle_mode   = 0;   // bit 0: sender idles, bit 1: receiver stalls
	logic req_taken  = 1'b0;
	logic [15:0] hot_base;

	always #4 clk = ~clk;

	// apply one access to the shadow RAM and return its response word
	function automatic ram_reply_t serve_access(ram_access_t a);
		ram_reply_t  r;
		int unsigned nbytes;
		int unsigned lane;
		logic [15:0] base;
		logic [15:0] addr;
		nbytes = 1 << a.access_size;
		base = a.byte_address & ~16'(nbytes - 1);
		r.read_data = '0;
		r.accepted = 1'b1;
		if (a.cmd == CmdWr) begin
			if (protect_shadow) begin
				r.accepted = 1'b0;
			end else begin
				for (int i = 0; i < nbytes; i++) begin
					lane = a.big_endian ? nbytes - 1 - i : i;
					addr = base + 16'(i);
					shadow_ram[addr[15:3]][addr[2:0]*8 +: 8] = a.write_data[lane*8 +: 8];
				end
			end
		end else begin
			for (int i = 0; i < nbytes; i++) begin
				lane = a.big_endian ? nbytes - 1 - i : i;
				addr = base + 16'(i);
				r.read_data[lane*8 +: 8] = shadow_ram[addr[15:3]][addr[2:0]*8 +: 8];
			end
		end
		return r;
	endfunction

	// random access: mostly a small hot window so reads find written bytes
	function automatic ram_access_t random_access(logic [15:0] window);
		ram_access_t a;
		int unsigned pick;
		a.cmd = $urandom_range(0, 1) ? CmdWr : CmdRd;
		a.access_size = 2'($urandom_range(0, 3));
		a.big_endian = 1'($urandom_range(0, 1));
		a.write_data = {$urandom, $urandom};
		pick = $urandom_range(0, 19);
		if (pick < 12)
			a.byte_address = window + 16'($urandom_range(0, 63));
		else if (pick < 15)
			a.byte_address = $urandom_range(0, 1) ? 16'($urandom_range(0, 31))
				: 16'hFFE0 + 16'($urandom_range(0, 31));
		else
			a.byte_address = 16'($urandom_range(0, 65535));
		return a;
	endfunction

	task automatic queue_access(logic cmd, logic [1:0] size, logic big, logic [15:0] addr,
		logic [63:0] data);
		ram_access_t a;
		a.cmd = cmd;
		a.access_size = size;
		a.big_endian = big;
		a.byte_address = addr;
		a.write_data = data;
		access_queue.push_back(a);
	endtask

	// hold until every queued word is taken and every response has come
	task automatic wait_drained();
		forever begin
			@(posedge clk);
			#1;
			if (access_queue.size() == 0 && !(req_ch.valid && !req_taken)
				&& expected_replies.size() == 0)
				break;
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_protect_reg(logic value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.write_protect <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// drive access words; advance only when the current word was taken
	always @(negedge clk) begin
		if (!req_ch.valid || req_taken) begin
			if (send_gap != 0) begin
				send_gap = send_gap - 1;
				req_ch.valid <= 1'b0;
			end else if (access_queue.size() != 0) begin
				ram_access_t a;
				a = access_queue.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.cmd <= a.cmd;
				req_ch.access_size <= a.access_size;
				req_ch.big_endian <= a.big_endian;
				req_ch.byte_address <= a.byte_address;
				req_ch.write_data <= a.write_data;
				if (idle_mode[0] && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 15);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// stall the response side in bursts
	always @(negedge clk) begin
		if (rsp_stall != 0) begin
			rsp_stall = rsp_stall - 1;
			rsp_ch.ready <= 1'b0;
		end else if (idle_mode[1] && $urandom_range(0, 5) == 0) begin
			rsp_stall = $urandom_range(1, 15) - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// check responses, then predict the word taken at this edge
	always @(posedge clk) begin
		req_taken = arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_replies.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected response word: read_data %h accepted %b",
						rsp_ch.read_data, rsp_ch.accepted);
			end else begin
				want = expected_replies.pop_front();
				if (rsp_ch.read_data !== want.read_data || rsp_ch.accepted !== want.accepted) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch: read_data exp %h got %h, accepted exp %b got %b",
							want.read_data, rsp_ch.read_data, want.accepted, rsp_ch.accepted);
				end
			end
		end
		if (arst_n && cfg_ch.valid && cfg_ch.ready)
			protect_shadow = cfg_ch.write_protect;
		if (req_taken)
			expected_replies.push_back(serve_access({req_ch.cmd, req_ch.access_size,
				req_ch.big_endian, req_ch.byte_address, req_ch.write_data}));
	end

	// drop the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CmdRd;
		req_ch.access_size = Size1;
		req_ch.big_endian = 1'b0;
		req_ch.byte_address = '0;
		req_ch.write_data = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.write_protect = 1'b0;
		protect_shadow = 1'b0;
		foreach (shadow_ram[i])
			shadow_ram[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: sizes, byte orders, unaligned and edge addresses
		idle_mode = 0;
		write_protect_reg(1'b0);
		queue_access(CmdRd, Size8, 1'b0, 16'h0000, 64'h0);
		queue_access(CmdWr, Size8, 1'b0, 16'h0000, 64'h0123_4567_89AB_CDEF);
		queue_access(CmdRd, Size8, 1'b1, 16'h0000, 64'h0);
		queue_access(CmdRd, Size1, 1'b1, 16'h0003, 64'h0);
		queue_access(CmdRd, Size2, 1'b1, 16'h0005, 64'h0);
		queue_access(CmdRd, Size4, 1'b0, 16'h0007, 64'h0);
		queue_access(CmdWr, Size2, 1'b1, 16'h0011, 64'hFFFF_FFFF_FFFF_A55A);
		queue_access(CmdWr, Size4, 1'b0, 16'h0016, 64'hFFFF_FFFF_DEAD_BEEF);
		queue_access(CmdWr, Size1, 1'b0, 16'h001F, 64'hFFFF_FFFF_FFFF_FF81);
		queue_access(CmdRd, Size8, 1'b0, 16'h0010, 64'h0);
		queue_access(CmdRd, Size8, 1'b1, 16'h0017, 64'h0);
		queue_access(CmdWr, Size8, 1'b1, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_access(CmdRd, Size1, 1'b0, 16'hFFFF, 64'h0);
		queue_access(CmdRd, Size2, 1'b0, 16'hFFFE, 64'h0);
		queue_access(CmdRd, Size4, 1'b1, 16'hFFFC, 64'h0);
		queue_access(CmdWr, Size1, 1'b1, 16'hFFFF, 64'h0);
		queue_access(CmdRd, Size8, 1'b0, 16'hFFF8, 64'h0);
		queue_access(CmdWr, Size8, 1'b0, 16'h8000, 64'h8000_0000_0000_0001);
		queue_access(CmdRd, Size8, 1'b1, 16'h8007, 64'h0);
		queue_access(CmdWr, Size4, 1'b1, 16'h7FFF, 64'h0000_0000_1234_5678);
		queue_access(CmdRd, Size2, 1'b0, 16'h7FFE, 64'h0);
		wait_drained();

		// directed: refused writes and reads under protection
		write_protect_reg(1'b1);
		queue_access(CmdWr, Size8, 1'b0, 16'h0000, 64'h0);
		queue_access(CmdWr, Size1, 1'b0, 16'hFFFF, 64'h0000_0000_0000_00AB);
		queue_access(CmdRd, Size8, 1'b0, 16'h0000, 64'h0);
		wait_drained();
		write_protect_reg(1'b0);
		queue_access(CmdRd, Size8, 1'b1, 16'hFFF8, 64'h0);
		wait_drained();

		// random phases; each pauses halfway until all responses are in
		for (int p = 0; p < PhaseCount; p++) begin
			case (p)
				0, 4, 5: idle_mode = 3;
				1:       idle_mode = 1;
				2:       idle_mode = 2;
				default: idle_mode = 0;
			endcase
			write_protect_reg((p == 2 || p == 4) ? 1'b1 : 1'b0);
			hot_base = 16'($urandom_range(0, 65535)) & 16'hFFC0;
			for (int n = 0; n < PhaseWords; n++) begin
				access_queue.push_back(random_access(hot_base));
				if (n == PhaseWords / 2 - 1)
					wait_drained();
			end
			wait_drained();
		end

		if (expected_replies.size() != 0)
			error_count++;
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
